// ----- src/pcm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_pkg
// Shared widths, command and status codes, and the controller command bundle
// for the priority ceiling mutex.
// ----------------------------------------------------------------------------
package pcm_pkg;

    localparam int PRIO_W       = 6;
    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 3;
    localparam int DEPTH_W      = 8;
    localparam int MAX_PRIO_DEF = 63;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 8'hFF;

    localparam logic [CMD_W-1:0] CMD_LOCK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TRY    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UNLOCK = 2'd2;

    localparam logic [STATUS_W-1:0] ST_GRANTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NESTED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BLOCKED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BUSY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_LOWERED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_HANDED  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FREED   = 3'd6;
    localparam logic [STATUS_W-1:0] ST_ERROR   = 3'd7;

    typedef struct packed {
        logic load;
        logic exec;
    } ctl_t;

endpackage

// ----- src/pcm_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_controller
// Two-state sequencer: takes a request, runs the update state, then raises
// the result strobe.
// ----------------------------------------------------------------------------
module pcm_controller (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output logic          done,
    output pcm_pkg::ctl_t ctl
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        ctl.load   = 1'b0;
        ctl.exec   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctl.exec   = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg == S_EXEC);
    assign done = done_reg;

endmodule

// ----- src/pcm_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_datapath
// Mutex state (depth, holder, wait bitmap, ceiling), registered highest
// waiter encoder, request capture and result registers.
// ----------------------------------------------------------------------------
module pcm_datapath #(
    parameter int MAX_PRIO = pcm_pkg::MAX_PRIO_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pcm_pkg::ctl_t                 ctl,
    input  logic [pcm_pkg::CMD_W-1:0]     command,
    input  logic [pcm_pkg::PRIO_W-1:0]    thread_prio,
    input  logic                          cfg_we,
    input  logic [pcm_pkg::PRIO_W-1:0]    cfg_data,
    output logic [pcm_pkg::STATUS_W-1:0]  status,
    output logic [pcm_pkg::PRIO_W-1:0]    holder_prio,
    output logic [pcm_pkg::PRIO_W-1:0]    run_prio,
    output logic [pcm_pkg::PRIO_W-1:0]    woken_prio,
    output logic [pcm_pkg::DEPTH_W-1:0]   lock_depth
);

    localparam int NPRIO = MAX_PRIO + 1;
    localparam int IDX_W = $clog2(NPRIO);
    localparam int PAD_W = 1 << IDX_W;
    localparam logic [pcm_pkg::PRIO_W-1:0] MAX_P = pcm_pkg::PRIO_W'(MAX_PRIO);

    logic [pcm_pkg::PRIO_W-1:0]   ceil_reg;
    logic [pcm_pkg::DEPTH_W-1:0]  depth_reg, depth_next;
    logic [pcm_pkg::PRIO_W-1:0]   holder_reg, holder_next;
    logic [NPRIO-1:0]             waiters_reg, waiters_next;
    logic [IDX_W-1:0]             top_reg, top_next;
    logic [pcm_pkg::CMD_W-1:0]    cmd_reg;
    logic [pcm_pkg::PRIO_W-1:0]   prio_reg;
    logic [pcm_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [pcm_pkg::PRIO_W-1:0]   holder_out_reg;
    logic [pcm_pkg::PRIO_W-1:0]   run_reg, run_next;
    logic [pcm_pkg::PRIO_W-1:0]   woken_reg, woken_next;
    logic [pcm_pkg::DEPTH_W-1:0]  depth_out_reg;

    logic [IDX_W-1:0]             prio_idx;
    logic [pcm_pkg::PRIO_W-1:0]   top_prio;
    logic                         ok;
    logic                         below;
    logic                         waiting;

    // halving search for the highest waiting priority
    always_comb
    begin
        logic [PAD_W-1:0] v;
        v        = PAD_W'(waiters_reg);
        top_next = '0;
        for (int k = IDX_W - 1; k >= 0; k--)
        begin
            if ((v >> (1 << k)) != '0)
            begin
                v           = v >> (1 << k);
                top_next[k] = 1'b1;
            end
        end
    end

    assign prio_idx = prio_reg[IDX_W-1:0];
    assign top_prio = pcm_pkg::PRIO_W'(top_reg);
    assign ok       = (prio_reg != '0) && (prio_reg <= MAX_P) && (ceil_reg <= MAX_P);
    assign below    = (ceil_reg == '0) || (prio_reg < ceil_reg);
    assign waiting  = waiters_reg[prio_idx];

    always_comb
    begin
        depth_next   = depth_reg;
        holder_next  = holder_reg;
        waiters_next = waiters_reg;
        status_next  = pcm_pkg::ST_ERROR;
        woken_next   = '0;
        if (ok && (cmd_reg == pcm_pkg::CMD_LOCK || cmd_reg == pcm_pkg::CMD_TRY))
        begin
            if (below && !waiting)
            begin
                if (depth_reg == '0)
                begin
                    depth_next  = 8'd1;
                    holder_next = prio_reg;
                    status_next = pcm_pkg::ST_GRANTED;
                end
                else if (holder_reg == prio_reg)
                begin
                    if (depth_reg != pcm_pkg::DEPTH_MAX)
                    begin
                        depth_next  = depth_reg + 8'd1;
                        status_next = pcm_pkg::ST_NESTED;
                    end
                end
                else if (cmd_reg == pcm_pkg::CMD_LOCK)
                begin
                    waiters_next[prio_idx] = 1'b1;
                    status_next            = pcm_pkg::ST_BLOCKED;
                end
                else
                begin
                    status_next = pcm_pkg::ST_BUSY;
                end
            end
        end
        else if (ok && cmd_reg == pcm_pkg::CMD_UNLOCK)
        begin
            if (depth_reg != '0 && holder_reg == prio_reg)
            begin
                if (depth_reg > 8'd1)
                begin
                    depth_next  = depth_reg - 8'd1;
                    status_next = pcm_pkg::ST_LOWERED;
                end
                else if (waiters_reg != '0)
                begin
                    if (ceil_reg == '0 || top_prio < ceil_reg)
                    begin
                        waiters_next[top_reg] = 1'b0;
                        holder_next           = top_prio;
                        woken_next            = top_prio;
                        status_next           = pcm_pkg::ST_HANDED;
                    end
                end
                else
                begin
                    depth_next  = '0;
                    holder_next = '0;
                    status_next = pcm_pkg::ST_FREED;
                end
            end
        end
    end

    always_comb
    begin
        if (holder_next == '0)
            run_next = '0;
        else if (ceil_reg != '0)
            run_next = ceil_reg;
        else
            run_next = holder_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ceil_reg    <= '0;
            depth_reg   <= '0;
            holder_reg  <= '0;
            waiters_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                ceil_reg <= cfg_data;
            if (ctl.exec)
            begin
                depth_reg   <= depth_next;
                holder_reg  <= holder_next;
                waiters_reg <= waiters_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (ctl.load)
        begin
            cmd_reg  <= command;
            prio_reg <= thread_prio;
        end
        if (ctl.exec)
        begin
            status_reg     <= status_next;
            holder_out_reg <= holder_next;
            run_reg        <= run_next;
            woken_reg      <= woken_next;
            depth_out_reg  <= depth_next;
        end
    end

    assign status      = status_reg;
    assign holder_prio = holder_out_reg;
    assign run_prio    = run_reg;
    assign woken_prio  = woken_reg;
    assign lock_depth  = depth_out_reg;

    a_holder_iff_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (holder_reg == '0) == (depth_reg == '0))
        else $error("holder and depth disagree");

    a_holder_not_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        !waiters_reg[holder_reg[IDX_W-1:0]] || holder_reg == '0 || holder_reg > MAX_P)
        else $error("holder is also in the wait bitmap");

    a_error_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec && status_next == pcm_pkg::ST_ERROR |=>
        $stable(depth_reg) && $stable(holder_reg) && $stable(waiters_reg))
        else $error("error transaction changed mutex state");

endmodule

// ----- src/priority_ceiling_mutex.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_ceiling_mutex
// Nesting hardware mutex with wait bitmap, priority hand-over and optional
// priority ceiling.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive command and thread_prio with start high; the
//   transaction is taken at the edge where start is high and busy is low.
//   busy is high for one cycle after each accepted request.
//   Result channel: status, holder_prio, run_prio, woken_prio and lock_depth
//   are valid for exactly one cycle while done is high, which is registered
//   from the update state. The receiver cannot stall; results must be taken
//   as shown. A new request is taken only after the update state, by when the
//   registered highest-waiter encoder has settled on the new wait bitmap
//   for the next update state.
//   Configuration: cfg_data loads the ceiling priority when cfg_valid and
//   cfg_ready are high; cfg_ready is always high. Write only while idle.
//   Reset: the mutex is free, depth 0, no waiters, ceiling 0, no result
//   pending.
// ----------------------------------------------------------------------------
module priority_ceiling_mutex #(
    parameter int MAX_PRIO = pcm_pkg::MAX_PRIO_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [pcm_pkg::CMD_W-1:0]     command,
    input  logic [pcm_pkg::PRIO_W-1:0]    thread_prio,
    output logic                          done,
    output logic [pcm_pkg::STATUS_W-1:0]  status,
    output logic [pcm_pkg::PRIO_W-1:0]    holder_prio,
    output logic [pcm_pkg::PRIO_W-1:0]    run_prio,
    output logic [pcm_pkg::PRIO_W-1:0]    woken_prio,
    output logic [pcm_pkg::DEPTH_W-1:0]   lock_depth,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pcm_pkg::PRIO_W-1:0]    cfg_data
);

    pcm_pkg::ctl_t ctl;

    assign cfg_ready = 1'b1;

    pcm_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl)
    );

    pcm_datapath #(
        .MAX_PRIO (MAX_PRIO)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .command     (command),
        .thread_prio (thread_prio),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .status      (status),
        .holder_prio (holder_prio),
        .run_prio    (run_prio),
        .woken_prio  (woken_prio),
        .lock_depth  (lock_depth)
    );

    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy ##1 done)
        else $error("accepted transaction did not produce a result");

    a_done_follows_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result strobe without a preceding update cycle");

    a_handed_has_woken: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == pcm_pkg::ST_HANDED |-> woken_prio != '0 &&
        woken_prio == holder_prio)
        else $error("hand-over without a woken waiter");

endmodule
